FILE: rtl/scdr_pkg.sv
// ----------------------------------------------------------------------------
// scdr_pkg: shared types and constants
// Sizes of the shadow constant store and the write port structure used
// between the top level and the shadow RAM.
// ----------------------------------------------------------------------------
package scdr_pkg;

    // registers in each of the two banks
    localparam int REGS_PER_BANK = 256;
    localparam int SLOTS         = 2 * REGS_PER_BANK;
    localparam int ADDR_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LANE_W        = 32;
    localparam int LANES         = 4;
    localparam int WORD_W        = LANE_W * LANES;
    localparam int IDX_W         = 8;

    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(SLOTS - 1);
    localparam logic [ADDR_W-1:0] BANK1_BASE = ADDR_W'(REGS_PER_BANK);

    // dirty range reset values (empty range)
    localparam logic [IDX_W-1:0] DIRTY_LOW_RST  = 8'd255;
    localparam logic [IDX_W-1:0] DIRTY_HIGH_RST = 8'd0;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // RAM write request
    typedef struct packed {
        logic  en;
        addr_t addr;
        word_t data;
    } ram_wr_t;

endpackage

FILE: rtl/scdr_shadow_ram.sv
// ----------------------------------------------------------------------------
// scdr_shadow_ram: shadow constant memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scdr_shadow_ram (
    input  logic             clk,
    input  scdr_pkg::ram_wr_t wr,
    input  logic             rd_en,
    input  scdr_pkg::addr_t  rd_addr,
    output scdr_pkg::word_t  rd_data
);
    import scdr_pkg::*;

    word_t mem [SLOTS];
    word_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/scdr_lane_cmp.sv
// ----------------------------------------------------------------------------
// scdr_lane_cmp: four-lane binary32 not-equal compare
// A NaN on either side differs; +0 and -0 compare equal.
// ----------------------------------------------------------------------------
module scdr_lane_cmp (
    input  scdr_pkg::word_t          new_word,
    input  scdr_pkg::word_t          old_word,
    output logic [scdr_pkg::LANES-1:0] differ
);
    import scdr_pkg::*;

    function automatic logic is_nan(input logic [LANE_W-1:0] x);
        is_nan = (x[LANE_W-2:0] > 31'h7F80_0000);
    endfunction

    function automatic logic lane_differs(input logic [LANE_W-1:0] a,
                                          input logic [LANE_W-1:0] b);
        logic [LANE_W-1:0] ab;
        ab = a | b;
        if (is_nan(a) || is_nan(b))
        begin
            lane_differs = 1'b1;
        end
        else if (ab[LANE_W-2:0] == '0)
        begin
            lane_differs = 1'b0;
        end
        else
        begin
            lane_differs = (a != b);
        end
    endfunction

    // lanes are independent
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            differ[i] = lane_differs(new_word[i*LANE_W +: LANE_W],
                                     old_word[i*LANE_W +: LANE_W]);
        end
    end

endmodule

FILE: rtl/shadow_constant_dirty_range_unit.sv
// ----------------------------------------------------------------------------
// shadow_constant_dirty_range_unit: shadow constant store with dirty range
// Compares each incoming four-lane constant with its shadow copy, writes it
// back when any lane differs and widens the bank's dirty register range.
// ----------------------------------------------------------------------------
//  channel | handshake            | word
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | bank, reg_index, lane0..lane3, last_in_call
//  output  | out_valid / out_ready| lanes_differ, written, dirty_low,
//          |                      | dirty_high, end_of_call
//
//  One word per cycle sustained while the output does not stall; an input
//  goes through the RAM read, then compare/write-back into the output register.
//  A write-back to the slot that the next word reads is forwarded.
//  After reset a clearing pass zeroes all 2*REGS_PER_BANK slots, one per
//  cycle; in_ready stays low until it ends.
//  A stalled output holds the compare stage, which then holds the input.
// ----------------------------------------------------------------------------
module shadow_constant_dirty_range_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        bank,
    input  logic [7:0]  reg_index,
    input  logic [31:0] lane0,
    input  logic [31:0] lane1,
    input  logic [31:0] lane2,
    input  logic [31:0] lane3,
    input  logic        last_in_call,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  lanes_differ,
    output logic        written,
    output logic [7:0]  dirty_low,
    output logic [7:0]  dirty_high,
    output logic        end_of_call
);
    import scdr_pkg::*;

    // clearing pass
    logic  clear_active_reg;
    addr_t clear_addr_reg;

    // compare stage
    logic             s1_valid_reg;
    logic             s1_bank_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_in_range_reg;
    addr_t            s1_addr_reg;
    word_t            s1_lanes_reg;
    logic             s1_last_reg;
    logic             s1_fwd_reg;
    word_t            s1_fwd_data_reg;

    // dirty ranges per bank
    logic [IDX_W-1:0] dirty_low_reg  [2];
    logic [IDX_W-1:0] dirty_high_reg [2];

    // output register
    logic             out_valid_reg;
    logic [LANES-1:0] out_differ_reg;
    logic             out_written_reg;
    logic [IDX_W-1:0] out_low_reg;
    logic [IDX_W-1:0] out_high_reg;
    logic             out_last_reg;

    logic             in_fire;
    logic             s1_adv;
    logic             in_range;
    addr_t            in_addr;
    word_t            in_word;
    word_t            rd_data;
    word_t            old_word;
    logic [LANES-1:0] differ;
    logic [LANES-1:0] s1_mask;
    logic             s1_write;
    logic [IDX_W-1:0] cur_low;
    logic [IDX_W-1:0] cur_high;
    logic [IDX_W-1:0] new_low;
    logic [IDX_W-1:0] new_high;
    ram_wr_t          ram_wr;

    // input decode
    assign in_word  = {lane3, lane2, lane1, lane0};
    assign in_range = (32'(reg_index) < REGS_PER_BANK);
    assign in_addr  = bank ? (BANK1_BASE + ADDR_W'(reg_index)) : ADDR_W'(reg_index);

    // handshake
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clear_active_reg && (!s1_valid_reg || s1_adv);
    assign in_fire  = in_valid && in_ready;

    // compare against shadow (forwarded on back-to-back same slot)
    assign old_word = s1_fwd_reg ? s1_fwd_data_reg : rd_data;

    scdr_lane_cmp u_cmp (
        .new_word (s1_lanes_reg),
        .old_word (old_word),
        .differ   (differ)
    );

    assign s1_mask  = s1_in_range_reg ? differ : '0;
    assign s1_write = s1_adv && (s1_mask != '0);

    // dirty range after this update
    assign cur_low  = dirty_low_reg[s1_bank_reg];
    assign cur_high = dirty_high_reg[s1_bank_reg];
    assign new_low  = (s1_mask != '0 && cur_low > s1_idx_reg) ? s1_idx_reg : cur_low;
    assign new_high = (s1_mask != '0 && cur_high < s1_idx_reg) ? s1_idx_reg : cur_high;

    // RAM write: clearing pass or write-back
    always_comb
    begin
        ram_wr.en   = clear_active_reg || s1_write;
        ram_wr.addr = clear_active_reg ? clear_addr_reg : s1_addr_reg;
        ram_wr.data = clear_active_reg ? '0 : s1_lanes_reg;
    end

    scdr_shadow_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_en   (in_fire),
        .rd_addr (in_addr),
        .rd_data (rd_data)
    );

    // clearing pass sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == LAST_SLOT)
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // compare stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // compare stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_bank_reg     <= bank;
            s1_idx_reg      <= reg_index;
            s1_in_range_reg <= in_range;
            s1_addr_reg     <= in_addr;
            s1_lanes_reg    <= in_word;
            s1_last_reg     <= last_in_call;
            s1_fwd_reg      <= s1_write && (s1_addr_reg == in_addr);
            s1_fwd_data_reg <= s1_lanes_reg;
        end
    end

    // dirty range registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_low_reg[0]  <= DIRTY_LOW_RST;
            dirty_low_reg[1]  <= DIRTY_LOW_RST;
            dirty_high_reg[0] <= DIRTY_HIGH_RST;
            dirty_high_reg[1] <= DIRTY_HIGH_RST;
        end
        else if (s1_write)
        begin
            dirty_low_reg[s1_bank_reg]  <= new_low;
            dirty_high_reg[s1_bank_reg] <= new_high;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_differ_reg  <= s1_mask;
            out_written_reg <= (s1_mask != '0);
            out_low_reg     <= new_low;
            out_high_reg    <= new_high;
            out_last_reg    <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign lanes_differ = out_differ_reg;
    assign written      = out_written_reg;
    assign dirty_low    = out_low_reg;
    assign dirty_high   = out_high_reg;
    assign end_of_call  = out_last_reg;

endmodule

FILE: rtl/scdr_checker.sv
// ----------------------------------------------------------------------------
// scdr_checker: port-level checks for the shadow constant unit
// Watches the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
module scdr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  lanes_differ,
    input logic        written,
    input logic [7:0]  dirty_low,
    input logic [7:0]  dirty_high,
    input logic        end_of_call
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(lanes_differ)
            && $stable(written) && $stable(dirty_low) && $stable(dirty_high)
            && $stable(end_of_call))
        else $error("output word changed while stalled");

    // written exactly when some lane differs
    a_written_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (written == (lanes_differ != 4'd0)))
        else $error("written flag does not match differ mask");

    // after a write the dirty range is not empty
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && written |-> dirty_low <= dirty_high)
        else $error("dirty range inverted after a write");

    // no input is taken right after reset (clearing pass)
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !in_ready)
        else $error("input taken during clearing pass");

endmodule

bind shadow_constant_dirty_range_unit scdr_checker u_scdr_checker (.*);

FILE: tb/shadow_constant_dirty_range_unit_tb.sv
// ----------------------------------------------------------------------------
// shadow_constant_dirty_range_unit_tb: self-checking bench for the shadow store
// Feeds constant register updates through the valid/ready input and checks
// every output word against an in-bench model of the shadow copy, the IEEE
// not-equal lane compare and the per-bank dirty range.
// ----------------------------------------------------------------------------
module shadow_constant_dirty_range_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scdr_pkg::*;

    localparam int NUM_UPDATES = 1300;
    localparam int IDLE_LIMIT  = 3000;   // covers the clearing pass and the long hold
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AFTER  = 300;    // words taken before the long hold starts
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic             bank;
        logic [7:0]       idx;
        logic [3:0][31:0] lane;
        logic             last;
    } update_t;

    typedef struct packed {
        logic [3:0] differ;
        logic       wr;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       eoc;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        bank = 1'b0;
    logic [7:0]  reg_index = '0;
    logic [31:0] lane0 = '0;
    logic [31:0] lane1 = '0;
    logic [31:0] lane2 = '0;
    logic [31:0] lane3 = '0;
    logic        last_in_call = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  lanes_differ;
    logic        written;
    logic [7:0]  dirty_low;
    logic [7:0]  dirty_high;
    logic        end_of_call;

    update_t pending_updates[$];
    reply_t  expected_replies[$];

    // model state
    logic [3:0][31:0] shadow_mem [SLOTS];
    logic [7:0]       range_lo [2];
    logic [7:0]       range_hi [2];

    // generator's record of the last lanes sent to each slot
    logic [3:0][31:0] last_sent [SLOTS];

    int   n_errors = 0;
    int   words_taken = 0;
    int   idle_cycles = 0;
    logic in_acc = 1'b0;

    shadow_constant_dirty_range_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .bank         (bank),
        .reg_index    (reg_index),
        .lane0        (lane0),
        .lane1        (lane1),
        .lane2        (lane2),
        .lane3        (lane3),
        .last_in_call (last_in_call),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .lanes_differ (lanes_differ),
        .written      (written),
        .dirty_low    (dirty_low),
        .dirty_high   (dirty_high),
        .end_of_call  (end_of_call)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    function automatic logic is_nan(logic [31:0] x);
        return (x & 32'h7FFF_FFFF) > 32'h7F80_0000;
    endfunction

    // IEEE not-equal: NaN always differs, +0 equals -0
    function automatic logic lane_differs(logic [31:0] a, logic [31:0] b);
        if (is_nan(a) || is_nan(b))
            return 1'b1;
        if (((a | b) & 32'h7FFF_FFFF) == 32'h0)
            return 1'b0;
        return a != b;
    endfunction

    function automatic reply_t apply_update(update_t u);
        reply_t r;
        int     slot;
        r = '0;
        if (int'(u.idx) < REGS_PER_BANK) begin
            slot = int'(u.bank) * REGS_PER_BANK + int'(u.idx);
            for (int i = 0; i < LANES; i++)
                r.differ[i] = lane_differs(u.lane[i], shadow_mem[slot][i]);
            if (r.differ != 4'b0) begin
                shadow_mem[slot] = u.lane;
                if (range_lo[u.bank] > u.idx)
                    range_lo[u.bank] = u.idx;
                if (range_hi[u.bank] < u.idx)
                    range_hi[u.bank] = u.idx;
                r.wr = 1'b1;
            end
        end
        r.lo  = range_lo[u.bank];
        r.hi  = range_hi[u.bank];
        r.eoc = u.last;
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    function automatic logic [31:0] pick_lane();
        case ($urandom_range(0, 13))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h3F80_0000;
            3:       return 32'hBF80_0000;
            4:       return 32'h7F80_0000;
            5:       return 32'hFF80_0000;
            6:       return 32'h7FC0_0000;
            7:       return 32'h7F80_0001;
            8:       return 32'hFFFF_FFFF;
            9:       return 32'h0000_0001;
            10:      return 32'h7F7F_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_update(logic b, logic [7:0] idx, logic [3:0][31:0] ln,
                               logic last);
        update_t u;
        u.bank = b;
        u.idx  = idx;
        u.lane = ln;
        u.last = last;
        pending_updates.push_back(u);
        last_sent[int'(b) * REGS_PER_BANK + int'(idx)] = ln;
    endtask

    // lanes for one register: often an exact repeat, sometimes sign-swapped zeros
    function automatic logic [3:0][31:0] make_lanes(logic b, logic [7:0] idx);
        logic [3:0][31:0] ln;
        int               mode;
        ln   = last_sent[int'(b) * REGS_PER_BANK + int'(idx)];
        mode = $urandom_range(0, 9);
        if (mode == 4) begin
            for (int i = 0; i < LANES; i++)
                if ((ln[i] & 32'h7FFF_FFFF) == 32'h0)
                    ln[i] = ln[i] ^ 32'h8000_0000;
        end else if (mode == 5) begin
            ln[$urandom_range(0, 3)] = pick_lane();
        end else if (mode >= 6) begin
            for (int i = 0; i < LANES; i++)
                if ($urandom_range(0, 1) == 1)
                    ln[i] = pick_lane();
        end
        return ln;
    endfunction

    task automatic build_stimulus();
        logic [3:0][31:0] ln;
        logic             b;
        int               n, base, win_lo, win_hi, kind;

        // directed: zero/-0 against the cleared store, NaN, inf, denormal,
        // partial lane change, extremes of index and bank, call boundaries
        push_update(1'b0, 8'd0,   {4{32'h0000_0000}}, 1'b0);
        push_update(1'b0, 8'd0,   {4{32'h8000_0000}}, 1'b1);
        push_update(1'b1, 8'd255, {4{32'h0000_0000}}, 1'b1);
        push_update(1'b0, 8'd5,   {32'h0, 32'h0, 32'h0, 32'h7FC0_0000}, 1'b0);
        push_update(1'b0, 8'd5,   {32'h0, 32'h0, 32'h0, 32'h7FC0_0000}, 1'b1);
        push_update(1'b1, 8'd255, {4{32'hFFFF_FFFF}}, 1'b0);
        push_update(1'b1, 8'd0,   {4{32'h7F80_0000}}, 1'b1);
        push_update(1'b1, 8'd0,   {4{32'h7F80_0000}}, 1'b0);
        push_update(1'b1, 8'd0,   {4{32'hFF80_0000}}, 1'b1);
        push_update(1'b0, 8'd10,  {4{32'h3F80_0000}}, 1'b0);
        push_update(1'b0, 8'd10,  {4{32'h8000_0000}}, 1'b0);
        push_update(1'b0, 8'd10,  {4{32'h0000_0000}}, 1'b1);
        push_update(1'b0, 8'd10,  {32'h0, 32'h0000_0001, 32'h0, 32'h0}, 1'b1);
        push_update(1'b0, 8'd10,  {32'h0, 32'h0000_0001, 32'h7F80_0001, 32'h0}, 1'b0);
        push_update(1'b0, 8'd255, {4{32'h7F7F_FFFF}}, 1'b1);
        push_update(1'b0, 8'd0,   {4{32'hFFFF_FFFF}}, 1'b0);
        push_update(1'b0, 8'd0,   {4{32'h0000_0000}}, 1'b1);
        push_update(1'b1, 8'd128, {32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h1},
                    1'b1);

        // random: mostly calls over consecutive registers, some repeated
        // hits on one register, some noise
        while (pending_updates.size() < NUM_UPDATES) begin
            kind   = $urandom_range(0, 9);
            b      = 1'($urandom_range(0, 1));
            win_lo = (pending_updates.size() < 250) ? 96 : 0;
            win_hi = (pending_updates.size() < 250) ? 160 : 255;
            if (kind == 0) begin
                ln = {$urandom(), $urandom(), $urandom(), $urandom()};
                push_update(b, 8'($urandom()), ln, 1'($urandom()));
            end else if (kind == 1) begin
                n    = $urandom_range(2, 5);
                base = $urandom_range(win_lo, win_hi);
                for (int k = 0; k < n; k++)
                    push_update(b, 8'(base), make_lanes(b, 8'(base)), k == n - 1);
            end else begin
                n    = $urandom_range(1, 8);
                base = $urandom_range(win_lo, win_hi - n + 1);
                for (int k = 0; k < n; k++)
                    push_update(b, 8'(base + k), make_lanes(b, 8'(base + k)),
                                k == n - 1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // input driver: bursts with random gaps, changes on the falling edge
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge clk) begin
        update_t u;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_acc) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_updates.size() > 0) begin
                u = pending_updates.pop_front();
                bank         <= u.bank;
                reg_index    <= u.idx;
                lane0        <= u.lane[0];
                lane1        <= u.lane[1];
                lane2        <= u.lane[2];
                lane3        <= u.lane[3];
                last_in_call <= u.last;
                in_valid     <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // output ready: a randomly chosen pattern, redrawn periodically, plus one long hold
    // ------------------------------------------------------------------
    int   rx_cycle  = 0;
    int   rx_mode   = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(negedge clk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!hold_done && words_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (rx_cycle % 3 != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor: check outputs, predict accepted inputs
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        reply_t want;
        in_acc <= rst_n && in_valid && in_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected output word", 0, 0);
                end else begin
                    want = expected_replies.pop_front();
                    if (lanes_differ !== want.differ)
                        report_mismatch("lanes_differ", 32'(lanes_differ),
                                        32'(want.differ));
                    if (written !== want.wr)
                        report_mismatch("written", 32'(written), 32'(want.wr));
                    if (dirty_low !== want.lo)
                        report_mismatch("dirty_low", 32'(dirty_low), 32'(want.lo));
                    if (dirty_high !== want.hi)
                        report_mismatch("dirty_high", 32'(dirty_high), 32'(want.hi));
                    if (end_of_call !== want.eoc)
                        report_mismatch("end_of_call", 32'(end_of_call),
                                        32'(want.eoc));
                end
            end
            if (in_valid && in_ready) begin
                expected_replies.push_back(apply_update(
                    update_t'{bank, reg_index, {lane3, lane2, lane1, lane0},
                              last_in_call}));
                words_taken++;
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("shadow_constant_dirty_range_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            shadow_mem[s] = '0;
            last_sent[s]  = '0;
        end
        for (int b = 0; b < 2; b++) begin
            range_lo[b] = DIRTY_LOW_RST;
            range_hi[b] = DIRTY_HIGH_RST;
        end
        build_stimulus();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (pending_updates.size() == 0 && !in_valid);
        wait (expected_replies.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (n_errors == 0 && expected_replies.size() == 0)
            $display("shadow_constant_dirty_range_unit verification clean");
        else
            $display("shadow_constant_dirty_range_unit verification failed");
        $finish;
    end

endmodule
